>>> hdl/pix2x2_pkg.sv
`default_nettype none
package pix2x2_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_MAX_HEIGHT = 512;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SIZE_W = 10;
  localparam int unsigned POS_W  = 9;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [1:0] EMIT_LAST = 2'd3;

endpackage
`default_nettype wire

>>> hdl/pixelate_two_by_two_average.sv
// 2x2 box-average pixelation of an 8-bit grey image.
// Input channel (in_valid_i/in_ready_o, pixel_i): one pixel per request in
// raster order. Config channel (cfg_valid_i/cfg_ready_o): index 0 sets the
// image width, index 1 the height; always ready, write only while idle.
// Output channel (out_valid_o/out_ready_i): for every aligned 2x2 block, on
// arrival of its bottom-right pixel, four requests carry the rounded average
// (sum+2)>>2 tagged with row and column: top-left, top-right, bottom-left,
// bottom-right; last_o marks the fourth. Odd trailing rows/columns give none.
// The first result passes the s1 stage, then the output register, after the
// bottom-right pixel is taken. Throughput: one pixel per cycle on even rows
// unless s1 stalls; on odd rows the result port bounds it (4 results/2 pixels).
// The previous row lives in a read-first single-port line memory; each pixel
// reads and overwrites its column entry at the same edge.
// Reset clears counters and neighbors, width/height return to 512; the line
// memory is not cleared. If the receiver stalls, results hold and the input
// stalls once the one-pixel stage behind the output holds a block pixel.
`default_nettype none
module pixelate_two_by_two_average #(
  parameter int unsigned MAX_WIDTH  = pix2x2_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = pix2x2_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [pix2x2_pkg::PIX_W-1:0]  pixel_i,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [pix2x2_pkg::SIZE_W-1:0] cfg_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [pix2x2_pkg::POS_W-1:0]  out_row_o,
  output      logic [pix2x2_pkg::POS_W-1:0]  out_col_o,
  output      logic [pix2x2_pkg::PIX_W-1:0]  value_o,
  output      logic                          last_o
);
  import pix2x2_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WLW = ($clog2(MAX_WIDTH + 1) > SIZE_W) ?
                                $clog2(MAX_WIDTH + 1) + 1 : SIZE_W + 1;
  localparam int unsigned HLW = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ?
                                $clog2(MAX_HEIGHT + 1) + 1 : SIZE_W + 1;

  logic [SIZE_W-1:0] width_q, height_q;
  logic [CW-1:0]     col_q;
  logic [RW-1:0]     row_q;

  logic [PIX_W-1:0]  line_mem_q [MAX_WIDTH];
  logic [PIX_W-1:0]  above_q;

  logic              s1_valid_q;
  logic [PIX_W-1:0]  s1_px_q;
  logic              s1_block_q;
  logic [CW-1:0]     s1_col_q;
  logic [RW-1:0]     s1_row_q;
  logic [PIX_W-1:0]  left_q, left_above_q;

  logic              o_valid_q;
  logic [1:0]        o_k_q;
  logic [CW-1:0]     o_col_q;
  logic [RW-1:0]     o_row_q;
  logic [PIX_W-1:0]  o_value_q;

  logic              in_acc, out_acc, o_free, s1_retire, s1_to_out;
  logic [WLW-1:0]    w_eff;
  logic [HLW-1:0]    h_eff;
  logic              row_end, frame_end;
  logic [PIX_W+1:0]  sum;
  logic [CW+POS_W-1:0] col_ext;
  logic [RW+POS_W-1:0] row_ext;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (WLW'(width_q) > WLW'(MAX_WIDTH)) begin
      w_eff = WLW'(MAX_WIDTH);
    end else if (width_q == '0) begin
      w_eff = WLW'(1);
    end else begin
      w_eff = WLW'(width_q);
    end
    if (HLW'(height_q) > HLW'(MAX_HEIGHT)) begin
      h_eff = HLW'(MAX_HEIGHT);
    end else if (height_q == '0) begin
      h_eff = HLW'(1);
    end else begin
      h_eff = HLW'(height_q);
    end
  end

  assign row_end   = (WLW'(col_q) + WLW'(1)) >= w_eff;
  assign frame_end = (HLW'(row_q) + HLW'(1)) >= h_eff;

  assign o_free     = !o_valid_q || (out_ready_i && (o_k_q == EMIT_LAST));
  assign s1_to_out  = s1_valid_q && s1_block_q && o_free;
  assign s1_retire  = s1_valid_q && (!s1_block_q || o_free);
  assign in_ready_o = !s1_valid_q || s1_retire;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = o_valid_q && out_ready_i;

  assign sum = (PIX_W+2)'(left_above_q) + (PIX_W+2)'(above_q) +
               (PIX_W+2)'(left_q) + (PIX_W+2)'(s1_px_q) + (PIX_W+2)'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // read-first: above_q gets the previous row's pixel of this column
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_q           <= line_mem_q[col_q];
      line_mem_q[col_q] <= pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      left_q       <= '0;
      left_above_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_retire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_retire) begin
        left_q       <= s1_px_q;
        left_above_q <= above_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q    <= pixel_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_block_q <= col_q[0] && row_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      o_k_q     <= '0;
    end else if (s1_to_out) begin
      o_valid_q <= 1'b1;
      o_k_q     <= '0;
    end else if (out_acc) begin
      o_k_q <= o_k_q + 2'd1;
      if (o_k_q == EMIT_LAST) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_to_out) begin
      o_col_q   <= s1_col_q;
      o_row_q   <= s1_row_q;
      o_value_q <= sum[PIX_W+1:2];
    end
  end

  // block corner is odd/odd, so the other corner just clears bit 0
  assign col_ext = {{(POS_W-1){1'b0}}, o_col_q >> 1, o_k_q[0]};
  assign row_ext = {{(POS_W-1){1'b0}}, o_row_q >> 1, o_k_q[1]};

  assign out_valid_o = o_valid_q;
  assign out_col_o   = col_ext[POS_W-1:0];
  assign out_row_o   = row_ext[POS_W-1:0];
  assign value_o     = o_value_q;
  assign last_o      = (o_k_q == EMIT_LAST);

endmodule
`default_nettype wire

>>> hdl/pix2x2_checker.sv
`default_nettype none
module pix2x2_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [pix2x2_pkg::POS_W-1:0] out_row_o,
  input wire logic [pix2x2_pkg::POS_W-1:0] out_col_o,
  input wire logic [pix2x2_pkg::PIX_W-1:0] value_o,
  input wire logic                         last_o,
  input wire logic                         cfg_ready_o
);
  import pix2x2_pkg::*;

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> out_row_o[0] && out_col_o[0])
    else $error("last result not at odd row and column");

  a_burst_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && $stable(value_o) && (out_col_o[0] != $past(out_col_o[0])))
    else $error("block burst broken");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_row_o) && $stable(out_col_o) &&
      $stable(value_o) && $stable(last_o))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cfg_ready_o)
    else $error("config port not ready");

endmodule

bind pixelate_two_by_two_average pix2x2_checker u_pix2x2_checker (.*);
`default_nettype wire

>>> dv/pixelate_two_by_two_average_tb.sv
`default_nettype none
module pixelate_two_by_two_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pix2x2_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PIXELS = 120;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             last;
  } tile_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic [PIX_W-1:0]  pixel = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index = CFG_IDX_WIDTH;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  out_row_o;
  logic [POS_W-1:0]  out_col_o;
  logic [PIX_W-1:0]  value_o;
  logic              last_o;

  pixelate_two_by_two_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  // predicted block state
  logic [SIZE_W-1:0] img_width = SIZE_RESET;
  logic [SIZE_W-1:0] img_height = SIZE_RESET;
  logic [PIX_W-1:0]  row_above [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]  left_px = '0;
  logic [PIX_W-1:0]  left_above_px = '0;
  int                col_pos = 0;
  int                row_pos = 0;

  tile_t            expected_tiles[$];
  logic [PIX_W-1:0] pixel_q[$];
  int               pixels_queued = 0;
  int               pixels_taken = 0;
  int               tiles_seen = 0;
  int               mismatches = 0;
  int               size_settings = 0;
  bit               idle_en = 1'b1;
  int               in_gap = 0;
  int               ready_hold = 0;
  int               stall_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_size(input logic [SIZE_W-1:0] reg_val, input int max_size);
    if (reg_val > max_size) return max_size;
    if (reg_val == 0) return 1;
    return int'(reg_val);
  endfunction

  function automatic void box_average_step(input logic [PIX_W-1:0] px);
    logic [PIX_W-1:0] above;
    logic [9:0]       sum;
    logic [PIX_W-1:0] avg;
    int               w;
    int               h;
    w = eff_size(img_width, DEF_MAX_WIDTH);
    h = eff_size(img_height, DEF_MAX_HEIGHT);
    above = row_above[col_pos];
    if (row_pos[0] && col_pos[0]) begin
      sum = 10'(left_above_px) + 10'(above) + 10'(left_px) + 10'(px);
      avg = PIX_W'((sum + 10'd2) >> 2);
      expected_tiles.push_back('{POS_W'(row_pos - 1), POS_W'(col_pos - 1), avg, 1'b0});
      expected_tiles.push_back('{POS_W'(row_pos - 1), POS_W'(col_pos), avg, 1'b0});
      expected_tiles.push_back('{POS_W'(row_pos), POS_W'(col_pos - 1), avg, 1'b0});
      expected_tiles.push_back('{POS_W'(row_pos), POS_W'(col_pos), avg, 1'b1});
    end
    left_above_px = above;
    left_px = px;
    row_above[col_pos] = px;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // pixel driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_valid <= 1'b1;
          pixel <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: tracks config and pixel requests, checks results, drives ready
  always @(posedge clk_i) begin
    tile_t got;
    tile_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        if (cfg_index == CFG_IDX_WIDTH) begin
          img_width = cfg_data;
        end else begin
          img_height = cfg_data;
        end
      end
      if (in_valid && in_ready_o) begin
        box_average_step(pixel);
        pixels_taken = pixels_taken + 1;
      end
      if (out_valid_o && out_ready) begin
        got = '{out_row_o, out_col_o, value_o, last_o};
        tiles_seen = tiles_seen + 1;
        if (expected_tiles.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("unexpected result: row %0d col %0d value %0d last %0d",
                     got.row, got.col, got.value, got.last);
          end
        end else begin
          want = expected_tiles.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.value !== want.value || got.last !== want.last) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display({"mismatch: exp row %0d col %0d value %0d last %0d,",
                        " got row %0d col %0d value %0d last %0d"},
                       want.row, want.col, want.value, want.last,
                       got.row, got.col, got.value, got.last);
            end
          end
        end
      end
      if (ready_hold != 0) begin
        ready_hold = ready_hold - 1;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        ready_hold = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_size(input logic idx, input logic [SIZE_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input int w_reg, input int h_reg);
    write_size(CFG_IDX_WIDTH, SIZE_W'(w_reg));
    write_size(CFG_IDX_HEIGHT, SIZE_W'(h_reg));
    size_settings = size_settings + 1;
  endtask

  // wait for all requests and results, then for the pipeline to go quiet
  task automatic settle();
    do @(posedge clk_i); while (pixels_taken != pixels_queued || expected_tiles.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] px);
    pixel_q.push_back(px);
    pixels_queued = pixels_queued + 1;
  endtask

  // whole frames only, so every line store entry is written before a block reads it
  task automatic run_frames(input int w_reg, input int h_reg, input int frames);
    int  n;
    int  total;
    bit  corners;
    set_size(w_reg, h_reg);
    total = frames * eff_size(SIZE_W'(w_reg), DEF_MAX_WIDTH) *
            eff_size(SIZE_W'(h_reg), DEF_MAX_HEIGHT);
    corners = ($urandom_range(0, 3) == 0);
    for (n = 0; n < total; n++) begin
      if (corners) begin
        case ($urandom_range(0, 3))
          0: push_pixel(8'd0);
          1: push_pixel(8'd1);
          2: push_pixel(8'd254);
          default: push_pixel(8'd255);
        endcase
      end else begin
        push_pixel(PIX_W'($urandom_range(0, 255)));
      end
    end
    settle();
  endtask

  initial begin
    logic [PIX_W-1:0] frame4 [16];
    logic [PIX_W-1:0] frame3 [9];
    int               i;
    int               w_reg;
    int               h_reg;
    int               start_px;
    frame4 = '{8'd255, 8'd255, 8'd0, 8'd0,
               8'd255, 8'd255, 8'd0, 8'd0,
               8'd1,   8'd1,   8'd2, 8'd2,
               8'd0,   8'd0,   8'd1, 8'd1};
    frame3 = '{8'd254, 8'd253, 8'd7,
               8'd128, 8'd127, 8'd9,
               8'd200, 8'd201, 8'd202};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full-scale, all-zero, and halves rounding up
    set_size(4, 4);
    for (i = 0; i < 16; i++) push_pixel(frame4[i]);
    settle();
    // odd trailing row and column
    set_size(3, 3);
    for (i = 0; i < 9; i++) push_pixel(frame3[i]);
    settle();

    // register extremes: zero and one on either side
    run_frames(2, 2, 2);
    idle_en = 1'b0;
    run_frames(4, 0, 1);
    idle_en = 1'b1;
    run_frames(1, 4, 1);
    run_frames(0, 3, 2);
    run_frames(5, 1, 2);

    start_px = pixels_queued;
    while (pixels_queued - start_px < RANDOM_PIXELS) begin
      idle_en = (pixels_queued - start_px < RANDOM_PIXELS * 3 / 4);
      w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(2, 6);
      h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(2, 6);
      run_frames(w_reg, h_reg, $urandom_range(1, 2));
    end

    mismatches = mismatches + expected_tiles.size();
    $display("Sent %0d pixels over %0d size settings (sizes 0 to 6, odd and even)",
             pixels_taken, size_settings);
    $display("Checked %0d results from %0d averaged blocks, %0d mismatches",
             tiles_seen, tiles_seen / 4, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
